// File: hw/rtl/grmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grmc_pkg: guest region map checker types and codes
// Command and result payloads, the token handed down the cell chain and the
// table update broadcast to all cells.
// ----------------------------------------------------------------------------
package grmc_pkg;

    localparam logic [2:0] KIND_MAP     = 3'd0;
    localparam logic [2:0] KIND_UNMAP   = 3'd1;
    localparam logic [2:0] KIND_PROTECT = 3'd2;
    localparam logic [2:0] KIND_READ    = 3'd3;
    localparam logic [2:0] KIND_WRITE   = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_RANGE       = 3'd1;
    localparam logic [2:0] ST_OVERLAP     = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_UNMAPPED    = 3'd4;
    localparam logic [2:0] ST_DENIED      = 3'd5;
    localparam logic [2:0] ST_FULL        = 3'd6;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_RW   = 2'd2;
    localparam logic [1:0] MODE_BAD  = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] base_or_address;
        logic [63:0] length;
        logic [1:0]  access_mode;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] region_offset;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [63:0] addr;
        logic [63:0] last;
        logic [1:0]  mode;
        logic        span_ok;
        logic        overlap;
        logic        free_found;
        logic        hit;
        logic        range_bad;
        logic        denied;
        logic [63:0] offset;
    } t_token;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_MAP     = 2'd1,
        OP_UNMAP   = 2'd2,
        OP_PROTECT = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] base;
        logic [63:0] last;
        logic [1:0]  mode;
    } t_commit;

endpackage : grmc_pkg
`default_nettype wire

// File: hw/rtl/grmc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grmc_cell: one region table entry
// Holds one region, folds its compare results into the passing token and
// marks itself as the target of a map, unmap or protect. Applies the table
// update when selected.
// ----------------------------------------------------------------------------
module grmc_cell
    import grmc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_token  i_tok,
    input  wire t_commit i_commit,
    output t_token       o_tok
);

    logic        r_valid;
    logic [63:0] r_base;
    logic [63:0] r_last;
    logic [1:0]  r_mode;
    logic        r_sel;
    logic        n_sel;
    t_token      r_tok;
    t_token      n_tok;

    logic in_region;
    logic base_match;

    assign in_region  = r_valid && (i_tok.addr >= r_base) && (i_tok.addr <= r_last);
    assign base_match = r_valid && (r_base == i_tok.addr);

    always_comb begin
        n_tok = i_tok;
        n_sel = r_sel;
        if (i_tok.valid) begin
            n_sel = 1'b0;
            unique case (i_tok.kind) inside
                KIND_MAP: begin
                    if (r_valid && (r_base <= i_tok.last) && (i_tok.addr <= r_last)) begin
                        n_tok.overlap = 1'b1;
                    end
                    if (!r_valid && !i_tok.free_found) begin
                        n_tok.free_found = 1'b1;
                        n_sel            = 1'b1;
                    end
                end
                KIND_UNMAP, KIND_PROTECT: begin
                    if (base_match) begin
                        n_tok.hit = 1'b1;
                        n_sel     = 1'b1;
                    end
                end
                KIND_READ, KIND_WRITE: begin
                    if (in_region) begin
                        n_tok.hit       = 1'b1;
                        n_tok.range_bad = i_tok.last > r_last;
                        n_tok.denied    = (i_tok.kind == KIND_WRITE) ? (r_mode != MODE_RW)
                                                                     : (r_mode == MODE_NONE);
                        n_tok.offset    = i_tok.addr - r_base;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_sel       <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
            r_sel       <= n_sel;
            if (r_sel) begin
                unique case (i_commit.op)
                    OP_MAP:   r_valid <= 1'b1;
                    OP_UNMAP: r_valid <= 1'b0;
                    default:  r_valid <= r_valid;
                endcase
            end
        end
        r_tok.kind       <= n_tok.kind;
        r_tok.addr       <= n_tok.addr;
        r_tok.last       <= n_tok.last;
        r_tok.mode       <= n_tok.mode;
        r_tok.span_ok    <= n_tok.span_ok;
        r_tok.overlap    <= n_tok.overlap;
        r_tok.free_found <= n_tok.free_found;
        r_tok.hit        <= n_tok.hit;
        r_tok.range_bad  <= n_tok.range_bad;
        r_tok.denied     <= n_tok.denied;
        r_tok.offset     <= n_tok.offset;
        if (r_sel && (i_commit.op == OP_MAP)) begin
            r_base <= i_commit.base;
            r_last <= i_commit.last;
        end
        if (r_sel && ((i_commit.op == OP_MAP) || (i_commit.op == OP_PROTECT))) begin
            r_mode <= i_commit.mode;
        end
    end

    assign o_tok = r_tok;

endmodule : grmc_cell
`default_nettype wire

// File: hw/rtl/guest_region_map_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// guest_region_map_checker: guest address region table with access checks
// An item is accepted when start is high and busy is low. It walks a chain of
// REGION_COUNT cells (16 by default), one cell per cycle, between a head
// register and the result register. busy stays high until the strobe cycle,
// in which o_done marks o_result for one cycle; the receiver cannot stall it.
// A new item may be started during the strobe cycle. Table updates land
// before that item reaches the first cell.
// ----------------------------------------------------------------------------
module guest_region_map_checker
    import grmc_pkg::*;
#(
    parameter int REGION_COUNT = 16
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_result   o_result
);

    t_token            w_tok [0:REGION_COUNT];
    logic [REGION_COUNT:0] w_vld;
    t_token            r_head;
    t_token            n_head;
    t_commit           r_commit;
    t_commit           n_commit;
    t_result           r_result;
    t_result           n_result;
    logic              r_busy;
    logic              r_done;
    logic              accept;
    t_token            w_end;
    logic [63:0]       len_m1;

    assign accept = start && !r_busy;
    assign len_m1 = i_cmd.length - 64'd1;

    always_comb begin
        n_head            = '0;
        n_head.valid      = accept;
        n_head.kind       = i_cmd.kind;
        n_head.addr       = i_cmd.base_or_address;
        n_head.last       = i_cmd.base_or_address + len_m1;
        n_head.mode       = i_cmd.access_mode;
        n_head.span_ok    = (i_cmd.length != 64'd0) && (len_m1 <= ~i_cmd.base_or_address);
    end

    assign w_tok[0] = r_head;

    genvar g;
    generate
        for (g = 0; g < REGION_COUNT; g++) begin : g_cell
            grmc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (w_tok[g]),
                .i_commit (r_commit),
                .o_tok    (w_tok[g+1])
            );
        end
        for (g = 0; g <= REGION_COUNT; g++) begin : g_vld
            assign w_vld[g] = w_tok[g].valid;
        end
    endgenerate

    assign w_end = w_tok[REGION_COUNT];

    always_comb begin
        n_result = '0;
        n_commit = '0;
        n_commit.op   = OP_NONE;
        n_commit.base = w_end.addr;
        n_commit.last = w_end.last;
        n_commit.mode = w_end.mode;
        unique case (w_end.kind) inside
            KIND_MAP: begin
                if (!w_end.span_ok) begin
                    n_result.status = ST_RANGE;
                end else if (w_end.mode == MODE_BAD) begin
                    n_result.status = ST_UNSUPPORTED;
                end else if (w_end.overlap) begin
                    n_result.status = ST_OVERLAP;
                end else if (!w_end.free_found) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_result.status = ST_OK;
                    n_commit.op     = OP_MAP;
                end
            end
            KIND_UNMAP: begin
                if (w_end.hit) begin
                    n_result.status = ST_OK;
                    n_commit.op     = OP_UNMAP;
                end else begin
                    n_result.status = ST_UNMAPPED;
                end
            end
            KIND_PROTECT: begin
                if (w_end.mode == MODE_BAD) begin
                    n_result.status = ST_UNSUPPORTED;
                end else if (w_end.hit) begin
                    n_result.status = ST_OK;
                    n_commit.op     = OP_PROTECT;
                end else begin
                    n_result.status = ST_UNMAPPED;
                end
            end
            KIND_READ, KIND_WRITE: begin
                if (!w_end.span_ok) begin
                    n_result.status = ST_RANGE;
                end else if (!w_end.hit) begin
                    n_result.status = ST_UNMAPPED;
                end else if (w_end.range_bad) begin
                    n_result.status = ST_RANGE;
                end else if (w_end.denied) begin
                    n_result.status = ST_DENIED;
                end else begin
                    n_result.status        = ST_OK;
                    n_result.region_offset = w_end.offset;
                end
            end
            default: begin
                n_result.status = ST_UNSUPPORTED;
            end
        endcase
        if (!w_end.valid) begin
            n_commit.op = OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_done       <= 1'b0;
            r_head.valid <= 1'b0;
            r_commit.op  <= OP_NONE;
        end else begin
            r_head.valid <= n_head.valid;
            r_commit.op  <= n_commit.op;
            r_done       <= w_end.valid;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (w_end.valid) begin
                r_busy <= 1'b0;
            end
        end
        r_head.kind       <= n_head.kind;
        r_head.addr       <= n_head.addr;
        r_head.last       <= n_head.last;
        r_head.mode       <= n_head.mode;
        r_head.span_ok    <= n_head.span_ok;
        r_head.overlap    <= n_head.overlap;
        r_head.free_found <= n_head.free_found;
        r_head.hit        <= n_head.hit;
        r_head.range_bad  <= n_head.range_bad;
        r_head.denied     <= n_head.denied;
        r_head.offset     <= n_head.offset;
        r_commit.base     <= n_commit.base;
        r_commit.last     <= n_commit.last;
        r_commit.mode     <= n_commit.mode;
        if (w_end.valid) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // one item in flight at most
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one token in the cell chain");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_vld) |-> busy)
        else $error("token in chain while not busy");

    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_commit.op != OP_NONE) |-> (o_done && (o_result.status == ST_OK)))
        else $error("table update without a successful result");

endmodule : guest_region_map_checker
`default_nettype wire

// File: tb/tb_guest_region_map_checker.sv
// ----------------------------------------------------------------------------
// tb_guest_region_map_checker: self-checking bench for the region table
// A directed list covers the span, mode, overlap and permission corners. It is
// followed by random phases: each phase fills a window with regions, then
// mixes maps, unmaps, protects, checks aimed at live regions, and noise. A
// local copy of the table predicts every result. The result is checked
// against that prediction when the strobe comes.
// ----------------------------------------------------------------------------
module tb_guest_region_map_checker;
    import grmc_pkg::*;

    localparam int         REGION_COUNT  = 16;
    localparam logic [1:0] MODE_RO       = 2'd1;
    localparam int         RANDOM_PHASES = 5;
    localparam int         PHASE_FILLS   = 20;
    localparam int         PHASE_ITEMS   = 200;
    localparam int         IDLE_LIMIT    = 500;
    localparam int         DRAIN_CYCLES  = REGION_COUNT + 8;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    t_cmd    cmd_backlog_q[$];
    t_result result_due_q[$];

    logic        region_live [REGION_COUNT] = '{default: 1'b0};
    logic [63:0] region_base [REGION_COUNT] = '{default: '0};
    logic [63:0] region_len  [REGION_COUNT] = '{default: '0};
    logic [1:0]  region_mode [REGION_COUNT] = '{default: '0};

    int fail_count   = 0;
    int idle_left    = 0;
    bit no_idle      = 1'b0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    guest_region_map_checker #(
        .REGION_COUNT(REGION_COUNT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    function automatic t_result region_table_apply(t_cmd c);
        t_result     r;
        logic [63:0] last;
        logic        span_good;
        int          slot;
        int          hit;
        int          i;
        r.status        = ST_OK;
        r.region_offset = '0;
        span_good = (c.length != '0) && ((c.length - 64'd1) <= ~c.base_or_address);
        last      = c.base_or_address + (c.length - 64'd1);
        slot      = -1;
        hit       = -1;
        case (c.kind)
            KIND_MAP: begin
                if (!span_good) begin
                    r.status = ST_RANGE;
                end else if (c.access_mode == MODE_BAD) begin
                    r.status = ST_UNSUPPORTED;
                end else begin
                    for (i = 0; i < REGION_COUNT; i++) begin
                        if (region_live[i]) begin
                            if (region_base[i] <= last &&
                                c.base_or_address <= region_base[i] + (region_len[i] - 64'd1))
                                hit = i;
                        end else if (slot < 0) begin
                            slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        r.status = ST_OVERLAP;
                    end else if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        region_live[slot] = 1'b1;
                        region_base[slot] = c.base_or_address;
                        region_len[slot]  = c.length;
                        region_mode[slot] = c.access_mode;
                    end
                end
            end
            KIND_UNMAP, KIND_PROTECT: begin
                for (i = 0; i < REGION_COUNT; i++)
                    if (slot < 0 && region_live[i] && region_base[i] == c.base_or_address)
                        slot = i;
                if (c.kind == KIND_PROTECT && c.access_mode == MODE_BAD) begin
                    r.status = ST_UNSUPPORTED;
                end else if (slot < 0) begin
                    r.status = ST_UNMAPPED;
                end else if (c.kind == KIND_UNMAP) begin
                    region_live[slot] = 1'b0;
                end else begin
                    region_mode[slot] = c.access_mode;
                end
            end
            KIND_READ, KIND_WRITE: begin
                if (!span_good) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = 0; i < REGION_COUNT; i++)
                        if (hit < 0 && region_live[i] && c.base_or_address >= region_base[i] &&
                            c.base_or_address <= region_base[i] + (region_len[i] - 64'd1))
                            hit = i;
                    if (hit < 0) begin
                        r.status = ST_UNMAPPED;
                    end else if (last > region_base[hit] + (region_len[hit] - 64'd1)) begin
                        r.status = ST_RANGE;
                    end else if (c.kind == KIND_WRITE ? (region_mode[hit] != MODE_RW)
                                                      : (region_mode[hit] == MODE_NONE)) begin
                        r.status = ST_DENIED;
                    end else begin
                        r.region_offset = c.base_or_address - region_base[hit];
                    end
                end
            end
            default: begin
                r.status = ST_UNSUPPORTED;
            end
        endcase
        return r;
    endfunction

    task automatic queue_cmd(logic [2:0] kind, logic [63:0] base, logic [63:0] len,
                             logic [1:0] mode);
        t_cmd c;
        c.kind            = kind;
        c.base_or_address = base;
        c.length          = len;
        c.access_mode     = mode;
        cmd_backlog_q = {cmd_backlog_q, c};
    endtask

    // driver
    always @(posedge i_clk) begin
        bit took;
        took = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (took) begin
                result_due_q = {result_due_q, region_table_apply(i_cmd)};
                idle_left = no_idle ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 31) == 0)
                    no_idle = !no_idle;
            end
            if (start && !took) begin
                start <= 1'b1;
            end else if (idle_left > 0) begin
                // gap counts only cycles in which the block is free
                if (!busy && !took)
                    idle_left--;
                start <= 1'b0;
            end else if (cmd_backlog_q.size() > 0) begin
                start <= 1'b1;
                i_cmd <= cmd_backlog_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (result_due_q.size() == 0) begin
                $error("unexpected result: status %0d offset %h",
                       o_result.status, o_result.region_offset);
                fail_count++;
            end else begin
                want = result_due_q.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.region_offset !== want.region_offset) begin
                    $error("region_offset: expected %h, got %h",
                           want.region_offset, o_result.region_offset);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] win;
        logic [63:0] rnd;
        logic [63:0] addr;
        logic [63:0] len;
        logic [63:0] off;
        logic [2:0]  kind;
        int          pick;
        int          roll;
        int          j;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(KIND_READ,    64'h0,    64'h1,    MODE_NONE);  // empty table
        queue_cmd(KIND_MAP,     64'h1000, 64'h0,    MODE_RO);    // zero length
        queue_cmd(KIND_MAP,     '1,       64'h2,    MODE_RO);    // wraps past top
        queue_cmd(KIND_MAP,     64'h1000, 64'h1000, MODE_BAD);
        queue_cmd(KIND_MAP,     '1,       64'h1,    MODE_RW);    // last byte of space
        queue_cmd(KIND_MAP,     64'h0,    64'h1000, MODE_RO);
        queue_cmd(KIND_MAP,     64'hFFF,  64'h10,   MODE_RW);    // overlap
        queue_cmd(KIND_MAP,     64'h2000, 64'h1000, MODE_NONE);
        queue_cmd(KIND_MAP,     64'h3000, 64'h100,  MODE_RW);
        queue_cmd(KIND_READ,    64'h10,   64'h10,   MODE_BAD);
        queue_cmd(KIND_WRITE,   64'h10,   64'h10,   MODE_NONE);  // read only
        queue_cmd(KIND_READ,    64'h2000, 64'h1,    MODE_NONE);  // no access
        queue_cmd(KIND_READ,    64'hFF8,  64'h10,   MODE_NONE);  // runs off the end
        queue_cmd(KIND_WRITE,   64'h3000, 64'h100,  MODE_NONE);  // exact fit
        queue_cmd(KIND_READ,    64'h0,    '1,       MODE_NONE);
        queue_cmd(KIND_WRITE,   '1,       64'h1,    MODE_NONE);
        queue_cmd(KIND_READ,    64'h10,   64'h0,    MODE_NONE);
        queue_cmd(KIND_PROTECT, 64'h2000, 64'h0,    MODE_RW);
        queue_cmd(KIND_WRITE,   64'h2FFF, 64'h1,    MODE_NONE);
        queue_cmd(KIND_PROTECT, 64'h3000, 64'h0,    MODE_BAD);
        queue_cmd(KIND_PROTECT, 64'h3010, 64'h0,    MODE_RO);    // not a base
        queue_cmd(KIND_UNMAP,   64'h1234, 64'h0,    MODE_NONE);
        queue_cmd(KIND_UNMAP,   64'h3000, '1,       MODE_BAD);
        queue_cmd(KIND_WRITE + 3'd1, 64'h0, 64'h1,  MODE_RW);    // reserved kinds
        queue_cmd(KIND_WRITE + 3'd3, '1,    '1,     MODE_BAD);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       win = 64'h0;
                1:       win = 64'hFFFF_FFFF_FFFF_0000;
                default: win = {$urandom, $urandom} & ~64'hF_FFFF;
            endcase
            for (j = 0; j < PHASE_FILLS; j++)
                queue_cmd(KIND_MAP, win + 64'(j) * 64'h1000,
                          64'($urandom_range(1, 'h1000)), 2'($urandom_range(0, 2)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // generate from the table as it stands now
                while (cmd_backlog_q.size() > 1)
                    @(posedge i_clk);
                pick = -1;
                roll = $urandom_range(0, REGION_COUNT - 1);
                for (j = 0; j < REGION_COUNT; j++)
                    if (pick < 0 && region_live[(roll + j) % REGION_COUNT])
                        pick = (roll + j) % REGION_COUNT;
                rnd  = {$urandom, $urandom};
                addr = win + 64'($urandom_range(0, 511)) * 64'h40;
                roll = $urandom_range(0, 99);
                if (roll < 22) begin
                    queue_cmd(KIND_MAP, addr, 64'($urandom_range(1, 'h400)),
                              2'($urandom_range(0, 3)));
                end else if (roll < 42) begin
                    if (pick >= 0 && $urandom_range(0, 4) != 0)
                        addr = region_base[pick];
                    queue_cmd(roll < 32 ? KIND_UNMAP : KIND_PROTECT, addr, rnd,
                              2'($urandom_range(0, 3)));
                end else if (roll < 92) begin
                    kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
                    len  = 64'($urandom_range(1, 64));
                    if (pick >= 0 && $urandom_range(0, 7) != 0) begin
                        off  = rnd % region_len[pick];
                        addr = region_base[pick] + off;
                        case ($urandom_range(0, 3))
                            0:       len = region_len[pick] - off;
                            1:       len = region_len[pick] - off + 64'd1;
                            default: len = 64'($urandom_range(1, 64));
                        endcase
                    end
                    queue_cmd(kind, addr, len, 2'($urandom_range(0, 3)));
                end else begin
                    len = $urandom_range(0, 3) == 0 ? 64'h0 : {$urandom, $urandom};
                    queue_cmd(3'($urandom_range(0, 7)), rnd, len, 2'($urandom_range(0, 3)));
                end
            end
        end

        while (cmd_backlog_q.size() > 0 || start || result_due_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
